@@ rtl/fsk4_symbol_shaping_modulator_defines.svh @@
// assertion macros for the 4fsk symbol shaping modulator
`ifndef FSK4_SYMBOL_SHAPING_MODULATOR_DEFINES_SVH
`define FSK4_SYMBOL_SHAPING_MODULATOR_DEFINES_SVH

// condition holds at every edge out of reset
`define FSM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fsk4 modulator check failed");

// consequent holds at the edge after the antecedent
`define FSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsk4 modulator check failed");

`endif

@@ rtl/fsk4ssm_pkg.sv @@
// shared constants, coefficient tables and helpers for the 4fsk modulator
`default_nettype none

package fsk4ssm_pkg;

  localparam int ACC_W           = 40;
  localparam int PULSE_TABLE_LEN = 40;
  localparam int LP_TABLE_LEN    = 32;
  localparam int SYMS_PER_ITEM   = 4;

  // configuration register indexes
  localparam logic REG_OUTER_TRIM = 1'b0;
  localparam logic REG_INNER_TRIM = 1'b1;

  // nominal 4fsk levels
  localparam logic signed [15:0] LEVEL_OUTER = 16'sd1220;
  localparam logic signed [15:0] LEVEL_INNER = 16'sd410;

  // dibit codes
  localparam logic [1:0] DIBIT_P3 = 2'b11;
  localparam logic [1:0] DIBIT_P1 = 2'b10;
  localparam logic [1:0] DIBIT_M1 = 2'b00;
  localparam logic [1:0] DIBIT_M3 = 2'b01;

  localparam logic signed [15:0] PULSE_COEF [PULSE_TABLE_LEN] = '{
    -16'sd897, -16'sd1636, -16'sd1840, -16'sd1278, 16'sd0, 16'sd1613, 16'sd2936,
    16'sd3310, 16'sd2315, 16'sd0, -16'sd3011, -16'sd5627, -16'sd6580, -16'sd4839,
    16'sd0, 16'sd7482, 16'sd16311, 16'sd24651, 16'sd30607, 16'sd32767, 16'sd30607,
    16'sd24651, 16'sd16311, 16'sd7482, 16'sd0, -16'sd4839, -16'sd6580, -16'sd5627,
    -16'sd3011, 16'sd0, 16'sd2315, 16'sd3310, 16'sd2936, 16'sd1613, 16'sd0,
    -16'sd1278, -16'sd1840, -16'sd1636, -16'sd897, 16'sd0
  };

  localparam logic signed [15:0] LP_COEF [LP_TABLE_LEN] = '{
    16'sd124, -16'sd188, -16'sd682, 16'sd1262, 16'sd556, -16'sd621, -16'sd1912,
    -16'sd911, 16'sd2058, 16'sd3855, 16'sd1234, -16'sd4592, -16'sd7692, -16'sd2799,
    16'sd8556, 16'sd18133, 16'sd18133, 16'sd8556, -16'sd2799, -16'sd7692,
    -16'sd4592, 16'sd1234, 16'sd3855, 16'sd2058, -16'sd911, -16'sd1912, -16'sd621,
    16'sd556, 16'sd1262, -16'sd682, -16'sd188, 16'sd124
  };

  // pulse coefficient, zero outside the table
  function automatic logic signed [15:0] pulse_at(input int idx);
    logic signed [15:0] c;
    c = '0;
    if (idx >= 0 && idx < PULSE_TABLE_LEN) begin
      c = PULSE_COEF[idx];
    end
    return c;
  endfunction

  // lowpass coefficient, zero outside the table
  function automatic logic signed [15:0] lp_at(input int idx);
    logic signed [15:0] c;
    c = '0;
    if (idx >= 0 && idx < LP_TABLE_LEN) begin
      c = LP_COEF[idx];
    end
    return c;
  endfunction

  // floor shift right 15 and saturate to 16 bits
  function automatic logic signed [15:0] sat_q15(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    logic signed [15:0]      r;
    sh = v >>> 15;
    if (sh > ACC_W'(32767)) begin
      r = 16'sh7fff;
    end else if (sh < -ACC_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = sh[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fsk4_symbol_shaping_modulator.sv @@
// 4fsk symbol mapper with raised cosine interpolator and lowpass fir on one shared mac
// one sample takes PULSE_PHASE_TAPS + LOWPASS_TAPS products, one per cycle while the mac issues,
//   with drain and push states between the passes; an item holds 4*INTERP_FACTOR samples,
//   and output stalls hold the sequencer before each sample is loaded
// one item at a time: input stall is high until its last sample is loaded
// synchronous reset clears trims, symbol history, sample fill count and control state
`default_nettype none
`include "fsk4_symbol_shaping_modulator_defines.svh"

module fsk4_symbol_shaping_modulator #(
  parameter int INTERP_FACTOR    = 5,
  parameter int PULSE_PHASE_TAPS = 8,
  parameter int LOWPASS_TAPS     = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               opcode,
  input  wire logic [7:0]         data_byte,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [15:0] sample,
  output      logic               last,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import fsk4ssm_pkg::*;

  localparam int PULSE_LEN = INTERP_FACTOR * PULSE_PHASE_TAPS;
  localparam int MAXT = (PULSE_PHASE_TAPS > LOWPASS_TAPS) ? PULSE_PHASE_TAPS : LOWPASS_TAPS;
  localparam int MW   = $clog2(MAXT);
  localparam int SW   = $clog2(PULSE_PHASE_TAPS);
  localparam int AW   = $clog2(LOWPASS_TAPS);
  localparam int FW   = $clog2(LOWPASS_TAPS + 1);
  localparam int PW   = $clog2(INTERP_FACTOR);

  localparam logic [MW-1:0] PT_LAST = MW'(PULSE_PHASE_TAPS - 1);
  localparam logic [MW-1:0] LT_LAST = MW'(LOWPASS_TAPS - 1);
  localparam logic [AW-1:0] AD_LAST = AW'(LOWPASS_TAPS - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(LOWPASS_TAPS);
  localparam logic [PW-1:0] P_LAST  = PW'(INTERP_FACTOR - 1);
  localparam logic [1:0]    S_LAST  = 2'(SYMS_PER_ITEM - 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SYM    = 3'd1;
  localparam logic [2:0] ST_PMAC   = 3'd2;
  localparam logic [2:0] ST_PDRAIN = 3'd3;
  localparam logic [2:0] ST_PPUSH  = 3'd4;
  localparam logic [2:0] ST_LMAC   = 3'd5;
  localparam logic [2:0] ST_LDRAIN = 3'd6;
  localparam logic [2:0] ST_LOUT   = 3'd7;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [1:0]       s;
  logic [PW-1:0]    p;
  logic [MW-1:0]    m;
  logic             item_silent;
  logic [7:0]       item_byte;
  logic signed [7:0] outer_trim;
  logic signed [7:0] inner_trim;

  logic signed [15:0] sym_hist [PULSE_PHASE_TAPS];
  logic signed [15:0] sym_new;
  logic [1:0]         dibit;

  logic signed [15:0] lp_mem [LOWPASS_TAPS];
  logic [AW-1:0]      wp;
  logic [AW-1:0]      rp;
  logic [FW-1:0]      fill;
  logic signed [15:0] rd_data;

  logic               op_vld;
  logic               op_lp;
  logic               op_zero;
  logic signed [15:0] op_coef;
  logic signed [15:0] op_sym;
  logic signed [15:0] op_data;
  logic               prod_vld;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0] coef_sel;
  logic signed [15:0] pulse_out;
  logic signed [15:0] lp_out;
  logic               issue;
  logic               pipe_empty;
  logic               out_load;
  logic               acc_clear;

  assign in_stall   = (state != ST_IDLE);
  assign issue      = (state == ST_PMAC) || (state == ST_LMAC);
  assign pipe_empty = !op_vld && !prod_vld;
  assign out_load   = (state == ST_LOUT) && (!out_valid || !out_stall);
  assign acc_clear  = (state == ST_SYM) || (state == ST_PPUSH) || out_load;
  assign pulse_out  = sat_q15(acc);
  assign lp_out     = sat_q15({{(ACC_W-32){acc[31]}}, acc[31:0]});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_trim <= '0;
      inner_trim <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTER_TRIM: outer_trim <= cfg_data;
        REG_INNER_TRIM: inner_trim <= cfg_data;
      endcase
    end
  end

  // dibit to level mapping
  always_comb begin
    dibit = 2'(item_byte >> (3'd6 - {s, 1'b0}));
    unique case (dibit)
      DIBIT_P3: sym_new = LEVEL_OUTER + 16'(outer_trim);
      DIBIT_P1: sym_new = LEVEL_INNER + 16'(inner_trim);
      DIBIT_M1: sym_new = -LEVEL_INNER - 16'(inner_trim);
      DIBIT_M3: sym_new = -LEVEL_OUTER - 16'(outer_trim);
    endcase
    if (item_silent) begin
      sym_new = '0;
    end
  end

  // coefficient for the tap being issued
  always_comb begin
    int pidx;
    int lidx;
    pidx = PULSE_LEN - 1 - int'(p) - int'(m) * INTERP_FACTOR;
    lidx = LOWPASS_TAPS - 1 - int'(m);
    if (state == ST_LMAC) begin
      coef_sel = lp_at(lidx);
    end else begin
      coef_sel = pulse_at(pidx);
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SYM;
      ST_SYM:    state_next = ST_PMAC;
      ST_PMAC:   if (m == PT_LAST) state_next = ST_PDRAIN;
      ST_PDRAIN: if (pipe_empty) state_next = ST_PPUSH;
      ST_PPUSH:  state_next = ST_LMAC;
      ST_LMAC:   if (m == LT_LAST) state_next = ST_LDRAIN;
      ST_LDRAIN: if (pipe_empty) state_next = ST_LOUT;
      ST_LOUT: begin
        if (out_load) begin
          priority if (p != P_LAST) state_next = ST_PMAC;
          else if (s != S_LAST)     state_next = ST_SYM;
          else                      state_next = ST_IDLE;
        end
      end
    endcase
  end

  // sequencer registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      s     <= '0;
      p     <= '0;
      m     <= '0;
    end else begin
      state <= state_next;
      if (issue) begin
        m <= (state_next == state) ? m + 1'b1 : '0;
      end
      if (state == ST_IDLE) begin
        s <= '0;
        p <= '0;
      end else if (state == ST_SYM) begin
        p <= '0;
      end else if (out_load) begin
        if (p != P_LAST) begin
          p <= p + 1'b1;
        end else begin
          s <= s + 1'b1;
        end
      end
    end
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_silent <= opcode;
      item_byte   <= data_byte;
    end
  end

  // symbol delay line, newest first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PULSE_PHASE_TAPS; k++) begin
        sym_hist[k] <= '0;
      end
    end else if (state == ST_SYM) begin
      sym_hist[0] <= sym_new;
      for (int k = 1; k < PULSE_PHASE_TAPS; k++) begin
        sym_hist[k] <= sym_hist[k-1];
      end
    end
  end

  // sample history pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (state == ST_PPUSH) begin
        wp <= (wp == AD_LAST) ? '0 : wp + 1'b1;
        rp <= wp;
        if (fill != FILL_MAX) begin
          fill <= fill + 1'b1;
        end
      end else if (state == ST_LMAC) begin
        rp <= (rp == '0) ? AD_LAST : rp - 1'b1;
      end
    end
  end

  // sample history memory, circular, registered read
  always_ff @(posedge clk) begin
    if (state == ST_PPUSH) begin
      lp_mem[wp] <= pulse_out;
    end
    if (state == ST_LMAC) begin
      rd_data <= lp_mem[rp];
    end
  end

  // operand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld <= 1'b0;
    end else begin
      op_vld <= issue;
    end
    op_lp   <= (state == ST_LMAC);
    op_zero <= (int'(m) >= int'(fill));
    op_coef <= coef_sel;
    op_sym  <= sym_hist[m[SW-1:0]];
  end

  assign op_data = op_lp ? (op_zero ? 16'sd0 : rd_data) : op_sym;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= op_vld;
    end
    prod <= op_coef * op_data;
  end

  // accumulator, low 32 bits wrap for the lowpass
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (acc_clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
    end
    if (out_load) begin
      sample <= lp_out;
      last   <= (s == S_LAST) && (p == P_LAST);
    end
  end

  // checks
  `FSM_ASSERT_ALWAYS(a_fill_range, fill <= FILL_MAX)
  `FSM_ASSERT_ALWAYS(a_mac_drained_at_output, !(state == ST_LOUT) || pipe_empty)
  `FSM_ASSERT_NEXT(a_last_ends_item,
                   out_load && (s == S_LAST) && (p == P_LAST),
                   state == ST_IDLE && out_valid && last)
  `FSM_ASSERT_NEXT(a_push_then_read_newest, state == ST_PPUSH, rp == $past(wp))

endmodule

`default_nettype wire
